### hdl/rpa_pkg.sv
// Shared types and codes of the reference-counted page allocator.
package rpa_pkg;

	localparam int OP_W   = 3;
	localparam int PAGE_W = 15;
	localparam int CNT_W  = 16;
	localparam int STS_W  = 2;

	localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
	localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
	localparam logic [OP_W-1:0] OP_FREE   = 3'd2;
	localparam logic [OP_W-1:0] OP_ADDREF = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;

	localparam logic [STS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STS_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [PAGE_W-1:0]        page;
		logic signed [CNT_W-1:0]  delta;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_out;
		logic [CNT_W-1:0]  count;
		logic [STS_W-1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic sweep_step;
		logic sweep_init;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic in_is_init;
		logic sweep_last;
	} sts_t;

endpackage

### hdl/rpa_ctrl.sv
// Sequencer of the page allocator: accept, sweep and execute phases.
module rpa_ctrl import rpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_SWEEP = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q, state_nxt;
	logic   init_q;
	logic   rsp_valid_q;
	logic   can_load;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign can_load  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.sweep_init = init_q;
		case (state_q)
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = init_q ? S_EXEC : S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = sts.in_is_init ? S_SWEEP : S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the output register can take the result
				if (can_load) begin
					cmd.exec  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			init_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.accept) begin
				init_q <= sts.in_is_init;
			end else if (cmd.exec) begin
				init_q <= 1'b0;
			end
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/rpa_datapath.sv
// Datapath of the page allocator: free stack, count memory, depth and result register.
module rpa_datapath import rpa_pkg::*; #(
	parameter int NUM_PAGES  = 32768,
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [PAGE_W-1:0] cfg_data,
	input  req_t              req,
	input  cmd_t              cmd,
	output sts_t              sts,
	output rsp_t              rsp
);

	localparam int PAGE_BITS  = $clog2(NUM_PAGES);
	localparam int DEPTH_BITS = $clog2(NUM_PAGES + 1);
	localparam int WIDE       = (PAGE_BITS > PAGE_W) ? PAGE_BITS : PAGE_W;
	localparam int CWIDE      = (COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W;

	logic [PAGE_BITS-1:0]  stack_mem [NUM_PAGES];
	logic [COUNT_BITS-1:0] cnt_mem   [NUM_PAGES];

	logic [PAGE_W-1:0]     fp_q;
	logic [PAGE_BITS-1:0]  idx_q;
	logic [DEPTH_BITS-1:0] depth_q;

	logic [OP_W-1:0]       op_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [COUNT_BITS-1:0] delta_q;
	logic                  range_ok_q;
	logic [PAGE_BITS-1:0]  stack_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;
	rsp_t                  rsp_q;

	logic [WIDE-1:0]       req_page_wide;
	logic [WIDE-1:0]       fp_wide;
	logic [WIDE-1:0]       idx_wide;
	logic [WIDE-1:0]       sweep_diff;
	logic [WIDE-1:0]       stack_wide;
	logic [CWIDE-1:0]      cnt_wide;
	logic [31:0]           delta_ext;
	logic                  req_range_ok;
	logic [PAGE_BITS-1:0]  req_addr;
	logic [DEPTH_BITS-1:0] depth_m1;
	logic [PAGE_BITS-1:0]  stack_ra;
	logic                  sweep_in_stack;

	logic                  cnt_we;
	logic [PAGE_BITS-1:0]  cnt_wa;
	logic [COUNT_BITS-1:0] cnt_wd;
	logic                  stack_we;
	logic [PAGE_BITS-1:0]  stack_wa;
	logic [PAGE_BITS-1:0]  stack_wd;
	logic [DEPTH_BITS-1:0] depth_nxt;
	rsp_t                  rsp_nxt;

	assign req_page_wide = WIDE'(req.page);
	assign fp_wide       = WIDE'(fp_q);
	assign idx_wide      = WIDE'(idx_q);
	assign stack_wide    = WIDE'(stack_rd_q);
	assign cnt_wide      = CWIDE'(cnt_rd_q);
	assign delta_ext     = {{(32 - CNT_W){req.delta[CNT_W-1]}}, req.delta};

	assign req_range_ok = (req_page_wide >= fp_wide) && (32'(req.page) < NUM_PAGES);
	assign req_addr     = req_page_wide[PAGE_BITS-1:0];
	assign depth_m1     = depth_q - DEPTH_BITS'(1);
	assign stack_ra     = depth_m1[PAGE_BITS-1:0];

	assign sweep_in_stack = cmd.sweep_init && (idx_wide >= fp_wide);
	assign sweep_diff     = idx_wide - fp_wide;

	assign sts.in_is_init = (req.op == OP_INIT);
	assign sts.sweep_last = (idx_q == PAGE_BITS'(NUM_PAGES - 1));

	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q <= '0;
		end else if (cfg_we) begin
			fp_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			depth_q <= '0;
		end else if (cmd.accept && sts.in_is_init) begin
			idx_q   <= '0;
			depth_q <= '0;
		end else if (cmd.sweep_step) begin
			idx_q <= idx_q + PAGE_BITS'(1);
			if (sweep_in_stack) begin
				depth_q <= depth_q + DEPTH_BITS'(1);
			end
		end else if (cmd.exec) begin
			depth_q <= depth_nxt;
		end
	end

	// latch the request beat and read both memories for it
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= req.op;
			page_q     <= req_addr;
			delta_q    <= delta_ext[COUNT_BITS-1:0];
			range_ok_q <= req_range_ok;
			stack_rd_q <= stack_mem[stack_ra];
			cnt_rd_q   <= cnt_mem[req_addr];
		end
	end

	always_comb begin
		cnt_we    = 1'b0;
		cnt_wa    = page_q;
		cnt_wd    = '0;
		stack_we  = 1'b0;
		stack_wa  = depth_q[PAGE_BITS-1:0];
		stack_wd  = page_q;
		depth_nxt = depth_q;
		rsp_nxt   = '0;
		if (cmd.sweep_step) begin
			// clear one count per cycle, and lay down a stack entry when the page is at or above fp_q
			cnt_we   = 1'b1;
			cnt_wa   = idx_q;
			stack_we = sweep_in_stack;
			stack_wa = sweep_diff[PAGE_BITS-1:0];
			stack_wd = idx_q;
		end else if (cmd.exec) begin
			case (op_q)
				OP_ALLOC: begin
					if (depth_q == '0) begin
						rsp_nxt.status = ST_EMPTY;
					end else begin
						cnt_we           = 1'b1;
						cnt_wa           = stack_rd_q;
						cnt_wd           = COUNT_BITS'(1);
						depth_nxt        = depth_m1;
						rsp_nxt.page_out = stack_wide[PAGE_W-1:0];
					end
				end
				OP_FREE: begin
					if (!range_ok_q) begin
						rsp_nxt.status = ST_RANGE;
					end else if (cnt_rd_q > COUNT_BITS'(1)) begin
						cnt_we = 1'b1;
						cnt_wd = cnt_rd_q - COUNT_BITS'(1);
					end else begin
						cnt_we = 1'b1;
						if (depth_q == DEPTH_BITS'(NUM_PAGES)) begin
							rsp_nxt.status = ST_FULL;
						end else begin
							stack_we  = 1'b1;
							depth_nxt = depth_q + DEPTH_BITS'(1);
						end
					end
				end
				OP_ADDREF: begin
					if (!range_ok_q) begin
						rsp_nxt.status = ST_RANGE;
					end else begin
						cnt_we        = 1'b1;
						cnt_wd        = cnt_rd_q + delta_q;
						rsp_nxt.count = cnt_wide[CNT_W-1:0];
					end
				end
				OP_READ: begin
					if (!range_ok_q) begin
						rsp_nxt.status = ST_RANGE;
					end else begin
						rsp_nxt.count = cnt_wide[CNT_W-1:0];
					end
				end
				default: begin
					rsp_nxt = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (stack_we) begin
			stack_mem[stack_wa] <= stack_wd;
		end
		if (cmd.exec) begin
			rsp_q <= rsp_nxt;
		end
	end

endmodule

### hdl/refcounted_page_allocator.sv
// Reference-counted page allocator: LIFO free stack and per-page counts.
//
// Request channel req_valid/req_stall/req carries op, page and delta; each
// request beat yields exactly one response beat on rsp_valid/rsp_stall/rsp
// (page_out, count, status). cfg_we/cfg_data write first_page; write it only
// while no request is in flight.
// Alloc, free, add-reference and read: the accept cycle reads the count
// memory and the free stack, the execute cycle writes back and loads the
// output register, and it is held while that register is full and stalled.
// The count read-modify-write keeps one request in flight. The response is
// valid the cycle after execute; a new request is taken while it still waits.
// Init sweeps the count memory and the free stack one page a cycle, then
// loads its response in the execute step.
// After reset a clearing pass zeroes every count; the request side stalls
// meanwhile, configuration writes are taken as ever.
// When the receiver stalls, the response is held and a finished request
// waits in its execute cycle until the output register frees.
module refcounted_page_allocator import rpa_pkg::*; #(
	parameter int NUM_PAGES  = 32768,
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [PAGE_W-1:0] cfg_data,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp
);

	cmd_t cmd;
	sts_t sts;

	rpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rpa_datapath #(
		.NUM_PAGES  (NUM_PAGES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule

### hdl/rpa_checker.sv
// Port-level assertions for the page allocator and their bind.
module rpa_port_asserts import rpa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request at a time: the cycle after an accept is always stalled
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous one in flight");

	// a new response follows a cycle in which requests were held off
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without an execute cycle");

	// an error response carries no page and no count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> (rsp.page_out == '0) && (rsp.count == '0))
		else $error("error response with nonzero payload");

endmodule

bind refcounted_page_allocator rpa_port_asserts u_rpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
